[src/tnpc_pkg.sv]
// Shared types and constants for the triangle near-plane clipper.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tnpc_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_NEAR_IDX = 1'b0;
  localparam logic signed [COORD_W-1:0] NEAR_RESET = 32'sd6554;
  localparam int NUM_SLOTS = 4;

  typedef enum logic [1:0] {
    CASE_ALL,
    CASE_ONE,
    CASE_TWO
  } clip_case_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  // Per-triangle payload that travels beside the divider and lerp stages
  typedef struct packed {
    clip_case_t                ccase;
    vtx_t                      p0;
    vtx_t                      p1;
    vtx_t                      p2;
    vtx_t                      va;
    vtx_t                      vb1;
    vtx_t                      vb2;
    logic signed [COORD_W-1:0] near;
  } tri_pl_t;

  typedef struct packed {
    logic       load;
    logic [1:0] last_idx;
  } ser_ctl_t;

endpackage

[src/tnpc_if.sv]
// Valid/ready channel interfaces for triangles in and vertices out.
// Depends on tnpc_pkg.
`timescale 1ns / 1ps

interface tnpc_tri_if import tnpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] a_x, a_y, a_z;
  logic signed [COORD_W-1:0] b_x, b_y, b_z;
  logic signed [COORD_W-1:0] c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface tnpc_vtx_if import tnpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic                      last_vertex;

  modport source (output valid, out_x, out_y, out_z, last_vertex, input ready);
  modport sink (input valid, out_x, out_y, out_z, last_vertex, output ready);
endinterface

[src/tnpc_div_lane.sv]
// Pipelined restoring divider: t = floor(un * 2^FRAC_BITS / ud), one bit per stage.
// Depends on tnpc_pkg. Stages advance only while en is high; t = 0 when ud is zero.
`timescale 1ns / 1ps

module tnpc_div_lane import tnpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [COORD_W:0]     un,
  input  logic [COORD_W:0]     ud,
  output logic [FRAC_BITS:0]   t
);

  localparam int DEPTH = FRAC_BITS + 1;
  localparam int RW = COORD_W + 2;

  logic [RW-1:0]      rem_r [DEPTH];
  logic [COORD_W:0]   ud_r  [DEPTH];
  logic [FRAC_BITS:0] q_r   [DEPTH];

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_stage
      logic [RW-1:0]      r_in;
      logic [COORD_W:0]   d_in;
      logic [FRAC_BITS:0] q_in;
      logic               ge;
      if (k == 0) begin : g_first
        // numerator never exceeds the divisor, so the top bit needs no shift
        assign r_in = {1'b0, un};
        assign d_in = ud;
        assign q_in = '0;
      end else begin : g_next
        assign r_in = {rem_r[k-1][RW-2:0], 1'b0};
        assign d_in = ud_r[k-1];
        assign q_in = q_r[k-1];
      end
      assign ge = r_in >= {1'b0, d_in};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (r_in - {1'b0, d_in}) : r_in;
          ud_r[k]  <= d_in;
          q_r[k]   <= {q_in[FRAC_BITS-1:0], ge};
        end
      end
    end
  endgenerate

  assign t = (ud_r[DEPTH-1] == '0) ? '0 : q_r[DEPTH-1];

endmodule

[src/tnpc_lerp.sv]
// Two-stage interpolator: a + floor((b - a) * t / 2^FRAC_BITS), saturated to 32 bits.
// Depends on tnpc_pkg.
`timescale 1ns / 1ps

module tnpc_lerp import tnpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] a,
  input  logic signed [COORD_W-1:0] b,
  input  logic [FRAC_BITS:0]        t,
  output logic signed [COORD_W-1:0] y
);

  localparam int PW = COORD_W + FRAC_BITS + 3;
  localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sh7FFF_FFFF);
  localparam logic signed [PW-1:0] SAT_MIN = -PW'(64'sh8000_0000);

  logic signed [COORD_W:0]   d;
  logic signed [PW-1:0]      p_nxt;
  logic signed [PW-1:0]      p_r;
  logic signed [COORD_W-1:0] a_r;
  logic signed [PW-1:0]      sum;
  logic signed [COORD_W-1:0] y_nxt;
  logic signed [COORD_W-1:0] y_r;

  always_comb begin
    d     = {b[COORD_W-1], b} - {a[COORD_W-1], a};
    p_nxt = PW'(d) * $signed(PW'(t));
    // arithmetic shift floors toward minus infinity
    sum   = PW'(a_r) + (p_r >>> FRAC_BITS);
    priority if (sum > SAT_MAX) y_nxt = SAT_MAX[COORD_W-1:0];
    else if (sum < SAT_MIN)     y_nxt = SAT_MIN[COORD_W-1:0];
    else                        y_nxt = sum[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
      a_r <= a;
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

[src/tnpc_serializer.sv]
// Output stage: holds one clipped polygon and sends it one vertex per transaction.
// Depends on tnpc_pkg and tnpc_vtx_if.
`timescale 1ns / 1ps

module tnpc_serializer import tnpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ser_ctl_t                 ctl,
  input  vtx_t [NUM_SLOTS-1:0]     slots,
  output logic                     can_load,
  tnpc_vtx_if.source               out_if
);

  logic                 busy_r;
  logic [1:0]           idx_r;
  logic [1:0]           lidx_r;
  vtx_t [NUM_SLOTS-1:0] slot_r;
  logic                 fin;

  assign fin      = busy_r && out_if.ready && (idx_r == lidx_r);
  assign can_load = !busy_r || fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      lidx_r <= '0;
    end else if (ctl.load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      lidx_r <= ctl.last_idx;
    end else if (fin) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_if.ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) slot_r <= slots;
  end

  assign out_if.valid       = busy_r;
  assign out_if.out_x       = slot_r[idx_r].x;
  assign out_if.out_y       = slot_r[idx_r].y;
  assign out_if.out_z       = slot_r[idx_r].z;
  assign out_if.last_vertex = (idx_r == lidx_r);

endmodule

[src/triangle_near_plane_clipper_core.sv]
// Triangle near-plane clipper top level.
// Depends on tnpc_pkg, tnpc_if, tnpc_div_lane, tnpc_lerp, tnpc_serializer.
//
// Usage: a triangle transaction on in_if (vertices a, b, c, signed Q16.16)
// is clipped against z = near_plane_z (APB register 0, byte address 0).
// The clipped polygon leaves on out_if as 3 or 4 vertex transactions, the
// final one with last_vertex set; a triangle entirely in front of the plane
// produces none. A triangle passes in order through classify, magnitudes,
// one divider stage per quotient bit, multiply, add/saturate, then the
// output register.
// Throughput: while the pipeline is not held, a new triangle can enter
// it every cycle; while out_if.ready is high, the output register sends
// one vertex per cycle.
// When out_if.ready is low and a finished triangle waits behind the output
// register, the whole pipeline holds in place and in_if.ready drops; nothing
// is lost or repeated. Synchronous reset clears all valid bits and loads
// near_plane_z with 6554 (about 0.1).
`timescale 1ns / 1ps

module triangle_near_plane_clipper_core import tnpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  tnpc_tri_if.sink           in_if,
  tnpc_vtx_if.source         out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DIV_D = FRAC_BITS + 1;
  localparam int LERP_D = 2;

  // ---------------- configuration ----------------
  logic signed [COORD_W-1:0] near_r;
  logic                      reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_NEAR_IDX);
  assign prdata  = reg_hit ? near_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) near_r <= NEAR_RESET;
    else if (psel && penable && pwrite && pready && reg_hit) near_r <= pwdata;
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic ser_can_load;
  logic lerp_v_r [LERP_D];

  assign adv         = !lerp_v_r[LERP_D-1] || ser_can_load;
  assign in_if.ready = adv;

  // ---------------- stage 0: classify ----------------
  vtx_t       vin [3];
  logic [2:0] ins;
  logic [1:0] cnt;
  logic [1:0] sel, nx, pv;
  tri_pl_t    s0_nxt, s0_r;
  logic       s0_v_r;

  always_comb begin
    vin[0] = '{x: in_if.a_x, y: in_if.a_y, z: in_if.a_z};
    vin[1] = '{x: in_if.b_x, y: in_if.b_y, z: in_if.b_z};
    vin[2] = '{x: in_if.c_x, y: in_if.c_y, z: in_if.c_z};
    for (int i = 0; i < 3; i++) ins[i] = vin[i].z >= near_r;
    cnt = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
    // lowest-index lone inside vertex (one inside) or lone outside one (two inside)
    if (cnt == 2'd1) sel = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
    else             sel = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
    unique case (sel)
      2'd0:    begin nx = 2'd1; pv = 2'd2; end
      2'd1:    begin nx = 2'd2; pv = 2'd0; end
      default: begin nx = 2'd0; pv = 2'd1; end
    endcase
    s0_nxt.near = near_r;
    s0_nxt.va   = vin[sel];
    s0_nxt.vb1  = vin[nx];
    s0_nxt.vb2  = vin[pv];
    s0_nxt.p2   = vin[2];
    if (cnt == 2'd3) begin
      s0_nxt.ccase = CASE_ALL;
      s0_nxt.p0    = vin[0];
      s0_nxt.p1    = vin[1];
    end else if (cnt == 2'd1) begin
      s0_nxt.ccase = CASE_ONE;
      s0_nxt.p0    = vin[sel];
      s0_nxt.p1    = vin[nx];
    end else begin
      s0_nxt.ccase = CASE_TWO;
      s0_nxt.p0    = vin[nx];
      s0_nxt.p1    = vin[pv];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (adv) s0_v_r <= in_if.valid && (cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (adv) s0_r <= s0_nxt;
  end

  // ---------------- stage 1: depth magnitudes ----------------
  function automatic logic [COORD_W:0] mag_diff(logic signed [COORD_W-1:0] p,
                                                logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
    return d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
  endfunction

  logic [COORD_W:0] un_r, ud1_r, ud2_r;
  tri_pl_t          s1_r;
  logic             s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= s0_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      un_r  <= mag_diff(s0_r.near, s0_r.va.z);
      ud1_r <= mag_diff(s0_r.vb1.z, s0_r.va.z);
      ud2_r <= mag_diff(s0_r.vb2.z, s0_r.va.z);
      s1_r  <= s0_r;
    end
  end

  // ---------------- divider stages ----------------
  logic [FRAC_BITS:0] t1, t2;
  tri_pl_t            dl_pl_r [DIV_D];
  logic               dl_v_r  [DIV_D];

  tnpc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div1 (
    .clk(clk), .en(adv), .un(un_r), .ud(ud1_r), .t(t1)
  );
  tnpc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div2 (
    .clk(clk), .en(adv), .un(un_r), .ud(ud2_r), .t(t2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_D; i++) dl_v_r[i] <= 1'b0;
    end else if (adv) begin
      dl_v_r[0] <= s1_v_r;
      for (int i = 1; i < DIV_D; i++) dl_v_r[i] <= dl_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_pl_r[0] <= s1_r;
      for (int i = 1; i < DIV_D; i++) dl_pl_r[i] <= dl_pl_r[i-1];
    end
  end

  // ---------------- interpolation stages ----------------
  tri_pl_t                   dq;
  logic signed [COORD_W-1:0] c1x, c1y, c2x, c2y;
  tri_pl_t                   lerp_pl_r [LERP_D];

  assign dq = dl_pl_r[DIV_D-1];

  tnpc_lerp #(.FRAC_BITS(FRAC_BITS)) u_l1x (
    .clk(clk), .en(adv), .a(dq.va.x), .b(dq.vb1.x), .t(t1), .y(c1x)
  );
  tnpc_lerp #(.FRAC_BITS(FRAC_BITS)) u_l1y (
    .clk(clk), .en(adv), .a(dq.va.y), .b(dq.vb1.y), .t(t1), .y(c1y)
  );
  tnpc_lerp #(.FRAC_BITS(FRAC_BITS)) u_l2x (
    .clk(clk), .en(adv), .a(dq.va.x), .b(dq.vb2.x), .t(t2), .y(c2x)
  );
  tnpc_lerp #(.FRAC_BITS(FRAC_BITS)) u_l2y (
    .clk(clk), .en(adv), .a(dq.va.y), .b(dq.vb2.y), .t(t2), .y(c2y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LERP_D; i++) lerp_v_r[i] <= 1'b0;
    end else if (adv) begin
      lerp_v_r[0] <= dl_v_r[DIV_D-1];
      for (int i = 1; i < LERP_D; i++) lerp_v_r[i] <= lerp_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lerp_pl_r[0] <= dq;
      for (int i = 1; i < LERP_D; i++) lerp_pl_r[i] <= lerp_pl_r[i-1];
    end
  end

  // ---------------- polygon assembly ----------------
  tri_pl_t              fq;
  vtx_t                 cr1, cr2;
  vtx_t [NUM_SLOTS-1:0] slots;
  ser_ctl_t             ctl;

  assign fq  = lerp_pl_r[LERP_D-1];
  assign cr1 = '{x: c1x, y: c1y, z: fq.near};
  assign cr2 = '{x: c2x, y: c2y, z: fq.near};

  always_comb begin
    ctl.load = lerp_v_r[LERP_D-1] && ser_can_load;
    slots[0] = fq.p0;
    unique case (fq.ccase)
      CASE_ALL: begin
        slots[1] = fq.p1;  slots[2] = fq.p2;  slots[3] = fq.p2;
        ctl.last_idx = 2'd2;
      end
      CASE_ONE: begin
        slots[1] = cr1;    slots[2] = cr2;    slots[3] = cr2;
        ctl.last_idx = 2'd2;
      end
      default: begin
        slots[1] = fq.p1;  slots[2] = cr2;    slots[3] = cr1;
        ctl.last_idx = 2'd3;
      end
    endcase
  end

  tnpc_serializer u_ser (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .slots(slots),
    .can_load(ser_can_load), .out_if(out_if)
  );

endmodule
